// File: rtl/core/i2c_master_transfer_sequencer_core_assert.svh
// Assertion macros used by the checker module of the transfer sequencer.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_CORE_ASSERT_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("transfer sequencer check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("transfer sequencer check failed");

`endif

// File: rtl/core/i2c_mts_pkg.sv
package i2c_mts_pkg;

    // Request and event selector
    localparam logic [1:0] FUNC_TX_REQ = 2'd0;
    localparam logic [1:0] FUNC_RX_REQ = 2'd1;
    localparam logic [1:0] FUNC_EVENT  = 2'd2;

    // Bus status codes
    localparam logic [3:0] ST_START     = 4'd0;
    localparam logic [3:0] ST_RSTART    = 4'd1;
    localparam logic [3:0] ST_SLAW_ACK  = 4'd2;
    localparam logic [3:0] ST_SLAW_NACK = 4'd3;
    localparam logic [3:0] ST_SLAR_ACK  = 4'd4;
    localparam logic [3:0] ST_SLAR_NACK = 4'd5;
    localparam logic [3:0] ST_TX_ACK    = 4'd6;
    localparam logic [3:0] ST_TX_NACK   = 4'd7;
    localparam logic [3:0] ST_RX_ACK    = 4'd8;
    localparam logic [3:0] ST_RX_NACK   = 4'd9;
    localparam logic [3:0] ST_BUS_ERR   = 4'd10;

    // Completion reports
    localparam logic [1:0] DONE_NONE   = 2'd0;
    localparam logic [1:0] DONE_TX     = 2'd1;
    localparam logic [1:0] DONE_RX     = 2'd2;
    localparam logic [1:0] DONE_BUSERR = 2'd3;

    // Transfer mode
    typedef enum logic [1:0] {
        MODE_READY = 2'd0,
        MODE_TX    = 2'd1,
        MODE_RX    = 2'd2
    } t_mode;

    // R/W bit of the address byte
    localparam logic RW_WRITE = 1'b0;
    localparam logic RW_READ  = 1'b1;

endpackage

// File: rtl/core/i2c_master_transfer_sequencer_core.sv
// Interrupt-style two-wire master transfer sequencer. Each accepted transaction is
// either a transmit or receive request or one bus status event, and yields exactly
// one result transaction that tells the bus driver what to do next (load the
// address or a data byte, release with ACK or NACK, stop) along with any received
// byte, its buffer position and a completion report. One transaction is accepted
// every clock cycle unless the input is stalled; its result appears in the output
// register on the following cycle, together with the update of the transfer state
// registers (mode, address, remaining count, position, keep-bus flag). The input
// stalls only while a result sits in the output register under a downstream
// stall; a result taken downstream in the same cycle frees the register for the
// next transaction, so back-to-back transactions see no gap.
module i2c_master_transfer_sequencer_core #(
    parameter int unsigned MAX_LENGTH = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [6:0]  i_slave_addr,
    input  logic [15:0] i_length,
    input  logic        i_keep_bus,
    input  logic [3:0]  i_status_code,
    input  logic [7:0]  i_tx_byte,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_accepted,
    output logic        o_load_data,
    output logic [7:0]  o_data_out,
    output logic        o_release_res,
    output logic        o_send_ack,
    output logic        o_send_stop,
    output logic        o_rx_valid,
    output logic [7:0]  o_rx_data,
    output logic [15:0] o_byte_index,
    output logic [1:0]  o_done_event,
    output logic [1:0]  o_busy_mode
);

    localparam logic [15:0] MaxLen = 16'(MAX_LENGTH);

    // Transfer state
    i2c_mts_pkg::t_mode r_mode, n_mode;
    logic [6:0]  r_target_addr, n_target_addr;
    logic [15:0] r_remaining, n_remaining;
    logic [15:0] r_position, n_position;
    logic        r_hold_bus, n_hold_bus;

    // Result register
    logic        r_out_valid;
    logic        r_accepted, n_accepted;
    logic        r_load_data, n_load_data;
    logic [7:0]  r_data_out, n_data_out;
    logic        r_release_res, n_release_res;
    logic        r_send_ack, n_send_ack;
    logic        r_send_stop, n_send_stop;
    logic        r_rx_valid, n_rx_valid;
    logic [7:0]  r_rx_data, n_rx_data;
    logic [15:0] r_byte_index, n_byte_index;
    logic [1:0]  r_done_event, n_done_event;

    logic in_take;
    logic is_tx;
    logic is_rx;

    // Hold input only while a finished result is blocked downstream
    assign o_stall = r_out_valid & i_stall;
    assign in_take = i_valid & ~o_stall;
    assign is_tx   = (r_mode == i2c_mts_pkg::MODE_TX);
    assign is_rx   = (r_mode == i2c_mts_pkg::MODE_RX);

    // Decode the transaction into the next action and the next state
    always_comb begin
        n_mode        = r_mode;
        n_target_addr = r_target_addr;
        n_remaining   = r_remaining;
        n_position    = r_position;
        n_hold_bus    = r_hold_bus;
        n_accepted    = 1'b0;
        n_load_data   = 1'b0;
        n_data_out    = 8'd0;
        n_release_res = 1'b0;
        n_send_ack    = 1'b0;
        n_send_stop   = 1'b0;
        n_rx_valid    = 1'b0;
        n_rx_data     = 8'd0;
        n_byte_index  = 16'd0;
        n_done_event  = i2c_mts_pkg::DONE_NONE;

        if (i_func == i2c_mts_pkg::FUNC_TX_REQ || i_func == i2c_mts_pkg::FUNC_RX_REQ) begin
            // Take a request only when idle and the length is nonzero
            if (r_mode == i2c_mts_pkg::MODE_READY && i_length != 16'd0) begin
                n_target_addr = i_slave_addr;
                n_remaining   = (i_length > MaxLen) ? MaxLen : i_length;
                n_position    = 16'd0;
                n_hold_bus    = i_keep_bus;
                n_mode        = (i_func == i2c_mts_pkg::FUNC_TX_REQ) ?
                                i2c_mts_pkg::MODE_TX : i2c_mts_pkg::MODE_RX;
                n_accepted    = 1'b1;
            end
        end else if (i_func == i2c_mts_pkg::FUNC_EVENT) begin
            case (i_status_code)
                i2c_mts_pkg::ST_START, i2c_mts_pkg::ST_RSTART: begin
                    // Load the address byte with its R/W bit
                    if (is_tx || is_rx) begin
                        n_load_data   = 1'b1;
                        n_data_out    = {r_target_addr,
                                         is_tx ? i2c_mts_pkg::RW_WRITE : i2c_mts_pkg::RW_READ};
                        n_release_res = 1'b1;
                    end
                end
                i2c_mts_pkg::ST_SLAW_ACK, i2c_mts_pkg::ST_TX_ACK: begin
                    if (is_tx) begin
                        if (r_remaining != 16'd0) begin
                            // Load the next transmit byte
                            n_load_data   = 1'b1;
                            n_data_out    = i_tx_byte;
                            n_release_res = 1'b1;
                            n_byte_index  = r_position;
                            n_position    = r_position + 16'd1;
                            n_remaining   = r_remaining - 16'd1;
                        end else begin
                            n_send_stop   = ~r_hold_bus;
                            n_release_res = ~r_hold_bus;
                            n_done_event  = i2c_mts_pkg::DONE_TX;
                            n_mode        = i2c_mts_pkg::MODE_READY;
                            n_remaining   = 16'd0;
                        end
                    end
                end
                i2c_mts_pkg::ST_SLAW_NACK: begin
                    // Address NACK always stops
                    if (is_tx) begin
                        n_send_stop   = 1'b1;
                        n_release_res = 1'b1;
                        n_done_event  = i2c_mts_pkg::DONE_TX;
                        n_mode        = i2c_mts_pkg::MODE_READY;
                        n_remaining   = 16'd0;
                    end
                end
                i2c_mts_pkg::ST_TX_NACK: begin
                    if (is_tx) begin
                        n_send_stop   = ~r_hold_bus;
                        n_release_res = ~r_hold_bus;
                        n_done_event  = i2c_mts_pkg::DONE_TX;
                        n_mode        = i2c_mts_pkg::MODE_READY;
                        n_remaining   = 16'd0;
                    end
                end
                i2c_mts_pkg::ST_SLAR_ACK: begin
                    if (is_rx) begin
                        n_release_res = 1'b1;
                        n_send_ack    = (r_remaining > 16'd1);
                    end
                end
                i2c_mts_pkg::ST_SLAR_NACK: begin
                    if (is_rx) begin
                        n_send_stop   = 1'b1;
                        n_release_res = 1'b1;
                        n_done_event  = i2c_mts_pkg::DONE_RX;
                        n_mode        = i2c_mts_pkg::MODE_READY;
                        n_remaining   = 16'd0;
                    end
                end
                i2c_mts_pkg::ST_RX_ACK: begin
                    if (is_rx) begin
                        // Hand out the byte and ACK only if more than one byte remains after
                        if (r_remaining != 16'd0) begin
                            n_rx_valid   = 1'b1;
                            n_rx_data    = i_rx_byte;
                            n_byte_index = r_position;
                            n_position   = r_position + 16'd1;
                            n_remaining  = r_remaining - 16'd1;
                        end
                        n_send_ack    = (r_remaining > 16'd2);
                        n_release_res = 1'b1;
                    end
                end
                i2c_mts_pkg::ST_RX_NACK: begin
                    if (is_rx) begin
                        // Last byte: hand it out, keep the position, finish
                        if (r_remaining != 16'd0) begin
                            n_rx_valid   = 1'b1;
                            n_rx_data    = i_rx_byte;
                            n_byte_index = r_position;
                        end
                        n_send_stop   = ~r_hold_bus;
                        n_release_res = ~r_hold_bus;
                        n_done_event  = i2c_mts_pkg::DONE_RX;
                        n_mode        = i2c_mts_pkg::MODE_READY;
                        n_remaining   = 16'd0;
                    end
                end
                i2c_mts_pkg::ST_BUS_ERR: begin
                    // Bus error stops in any mode and leaves the state alone
                    n_send_stop   = 1'b1;
                    n_release_res = 1'b1;
                    n_done_event  = i2c_mts_pkg::DONE_BUSERR;
                end
                default: begin
                end
            endcase
        end
    end

    // Advance state and capture the result on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= i2c_mts_pkg::MODE_READY;
            r_target_addr <= 7'd0;
            r_remaining   <= 16'd0;
            r_position    <= 16'd0;
            r_hold_bus    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_take) begin
                r_mode        <= n_mode;
                r_target_addr <= n_target_addr;
                r_remaining   <= n_remaining;
                r_position    <= n_position;
                r_hold_bus    <= n_hold_bus;
                r_out_valid   <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    // Result payload, held while stalled
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_accepted    <= n_accepted;
            r_load_data   <= n_load_data;
            r_data_out    <= n_data_out;
            r_release_res <= n_release_res;
            r_send_ack    <= n_send_ack;
            r_send_stop   <= n_send_stop;
            r_rx_valid    <= n_rx_valid;
            r_rx_data     <= n_rx_data;
            r_byte_index  <= n_byte_index;
            r_done_event  <= n_done_event;
        end
    end

    // Busy mode reported is the state after the transaction
    assign o_valid       = r_out_valid;
    assign o_accepted    = r_accepted;
    assign o_load_data   = r_load_data;
    assign o_data_out    = r_data_out;
    assign o_release_res = r_release_res;
    assign o_send_ack    = r_send_ack;
    assign o_send_stop   = r_send_stop;
    assign o_rx_valid    = r_rx_valid;
    assign o_rx_data     = r_rx_data;
    assign o_byte_index  = r_byte_index;
    assign o_done_event  = r_done_event;
    assign o_busy_mode   = r_mode;

endmodule

// File: rtl/core/i2c_mts_checker.sv
`include "i2c_master_transfer_sequencer_core_assert.svh"

module i2c_mts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_accepted,
    input logic        o_load_data,
    input logic [7:0]  o_data_out,
    input logic        o_release_res,
    input logic        o_send_stop,
    input logic        o_rx_valid,
    input logic [1:0]  o_done_event,
    input logic [1:0]  o_busy_mode
);

    logic is_busy;
    logic xfer_done;

    // Decode busy mode and transfer completion
    assign is_busy   = (o_busy_mode != i2c_mts_pkg::MODE_READY);
    assign xfer_done = (o_done_event == i2c_mts_pkg::DONE_TX) ||
                       (o_done_event == i2c_mts_pkg::DONE_RX);

    // A stop always comes with a release of the bus
    `MTS_ASSERT_IMPL(a_stop_releases, i_clk, i_rst_n, o_valid && o_send_stop, o_release_res)

    // A taken request leaves the block busy
    `MTS_ASSERT_IMPL(a_accept_busy, i_clk, i_rst_n, o_valid && o_accepted, is_busy)

    // Transmit or receive completion leaves the block ready
    `MTS_ASSERT_IMPL(a_done_ready, i_clk, i_rst_n, o_valid && xfer_done, !is_busy)

    // Loading a byte and handing one out never share a result
    `MTS_ASSERT_IMPL(a_load_xor_rx, i_clk, i_rst_n, o_valid && o_load_data, !o_rx_valid)

    // A stalled result stays put
    `MTS_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data_out))

endmodule

bind i2c_master_transfer_sequencer_core i2c_mts_checker u_i2c_mts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_accepted    (o_accepted),
    .o_load_data   (o_load_data),
    .o_data_out    (o_data_out),
    .o_release_res (o_release_res),
    .o_send_stop   (o_send_stop),
    .o_rx_valid    (o_rx_valid),
    .o_done_event  (o_done_event),
    .o_busy_mode   (o_busy_mode)
);
